### design/marc_pkg.sv
// ---------------------------------------------------------------------------
// marc_pkg: shared types and constants of the median/average ramp conditioner
// Sample width, configuration register map and reset values, smoothing
// weights and the reciprocal used for the divide by ten.
// ---------------------------------------------------------------------------
package marc_pkg;

  localparam int unsigned DATA_W = 8;
  typedef logic [DATA_W-1:0] data_t;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CLAMP_MIN = 2'd0;
  localparam cfg_idx_t REG_CLAMP_MAX = 2'd1;
  localparam cfg_idx_t REG_RAMP_STEP = 2'd2;

  localparam data_t CLAMP_MIN_RST = 8'd0;
  localparam data_t CLAMP_MAX_RST = 8'd100;
  localparam data_t RAMP_STEP_RST = 8'd5;

  // Default window length
  localparam int unsigned WINDOW_TAPS_DEF = 5;

  // Smoothing: (5*newest + 3*middle + 2*oldest) / 10
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned W_NEW   = 5;
  localparam int unsigned W_MID   = 3;
  localparam int unsigned W_OLD   = 2;
  // ceil(2^16 / 10); exact for every sum below 2560
  localparam int unsigned RECIP_SH = 16;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned RECIP    = 6554;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;

endpackage

### design/marc_median.sv
// ---------------------------------------------------------------------------
// marc_median: median of the sample window
// Ranks every entry against all others in parallel (ties broken by slot
// position) and selects the entry whose rank is the middle one.
// ---------------------------------------------------------------------------
module marc_median #(
  parameter int unsigned TAPS = marc_pkg::WINDOW_TAPS_DEF
) (
  input  marc_pkg::data_t win_i [TAPS],
  output marc_pkg::data_t med_o
);
  import marc_pkg::*;

  localparam int unsigned RANK_W = $clog2(TAPS);
  localparam int unsigned MID    = TAPS / 2;

  logic [RANK_W-1:0] rank [TAPS];

  // Count the entries that sort ahead of each entry
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (j != i) begin
          if ((win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // Pick the entry of middle rank; ranks are unique so one term is live
  always_comb begin
    med_o = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        med_o = med_o | win_i[i];
      end
    end
  end

endmodule

### design/median_average_ramp_conditioner.sv
// ---------------------------------------------------------------------------
// median_average_ramp_conditioner: median filter, smoother and ramp limiter
// Clamps each speed sample, takes the median of a circular window, smooths
// the last three medians and slew-limits the drive value.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one speed sample per beat (valid/ready).
//   out_*  : one result per input beat: window median, smoothed value and
//            drive value (valid/ready).
//   cfg_*  : register writes (index, data); always ready. Index 0 is the
//            lower clamp, 1 the upper clamp, 2 the ramp step; other indexes
//            are ignored. Write only while the block is empty.
// Pipeline: four registered stages (window update, median, weighted average, ramp).
// Throughput: one sample per cycle while out_ready is high; each of the four
//   stages holds one beat and moves on as soon as the stage after it has room.
// Reset: registers return to their defaults, the pipeline empties and the
//   drive value goes to zero; the first sample then seeds the window and
//   the median history.
// Stall: while out_ready is low the result holds; earlier stages keep
//   filling, and in_ready drops once every stage holds a beat.
// ---------------------------------------------------------------------------
module median_average_ramp_conditioner #(
  parameter int unsigned WINDOW_TAPS = marc_pkg::WINDOW_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  marc_pkg::data_t     in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output marc_pkg::data_t     out_median_value,
  output marc_pkg::data_t     out_smoothed_value,
  output marc_pkg::data_t     out_drive_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  marc_pkg::cfg_idx_t  cfg_index,
  input  marc_pkg::data_t     cfg_data
);
  import marc_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_TAPS);

  // Configuration
  data_t clamp_min_r, clamp_max_r, ramp_step_r;

  // Window state
  data_t             window_r   [WINDOW_TAPS];
  data_t             window_nxt [WINDOW_TAPS];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              primed_r;
  data_t             sat_hi, sat;

  // Pipeline stages
  logic  s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic  s1_first_r;
  data_t s1_raw_r;
  data_t hist_r [3];
  data_t med;
  data_t s2_med_r;
  data_t s3_med_r, s3_avg_r;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  data_t avg;
  data_t drive_r, drive_nxt;
  data_t out_med_r, out_avg_r;

  logic in_acc, s2_take, s3_take, s4_take;
  logic s1_free, s2_free, s3_free, out_free;

  // Stage flow: a stage takes a beat when the next one has room
  assign out_free = !out_valid_r || out_ready;
  assign s4_take  = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || s4_take;
  assign s3_take  = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_take;
  assign s2_take  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_take;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && s1_free;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_min_r <= CLAMP_MIN_RST;
      clamp_max_r <= CLAMP_MAX_RST;
      ramp_step_r <= RAMP_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLAMP_MIN: clamp_min_r <= cfg_data;
        REG_CLAMP_MAX: clamp_max_r <= cfg_data;
        REG_RAMP_STEP: ramp_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp: upper limit first, so the lower limit wins when they cross
  assign sat_hi = (in_sample > clamp_max_r) ? clamp_max_r : in_sample;
  assign sat    = (sat_hi < clamp_min_r) ? clamp_min_r : sat_hi;

  // Next window: seed with the raw sample on the first beat, then write slot
  always_comb begin
    for (int k = 0; k < WINDOW_TAPS; k++) begin
      window_nxt[k] = primed_r ? window_r[k] : in_sample;
      if (SLOT_W'(k) == slot_r) begin
        window_nxt[k] = sat;
      end
    end
    slot_nxt = (slot_r == SLOT_W'(WINDOW_TAPS - 1)) ? '0 : slot_r + SLOT_W'(1);
  end

  // Stage 1: window update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      slot_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r   <= 1'b1;
        slot_r   <= slot_nxt;
        primed_r <= 1'b1;
      end else if (s2_take) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      window_r   <= window_nxt;
      s1_first_r <= !primed_r;
      s1_raw_r   <= in_sample;
    end
  end

  // Stage 2: median of the newest window, shift into history
  marc_median #(
    .TAPS (WINDOW_TAPS)
  ) u_median (
    .win_i (window_r),
    .med_o (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_take) begin
      s2_v_r <= 1'b1;
    end else if (s3_take) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_med_r  <= med;
      hist_r[0] <= med;
      hist_r[1] <= s1_first_r ? s1_raw_r : hist_r[0];
      hist_r[2] <= s1_first_r ? s1_raw_r : hist_r[1];
    end
  end

  // Stage 3: weighted sum, divide by ten through the reciprocal
  assign sum  = SUM_W'(hist_r[0]) * SUM_W'(W_NEW)
              + SUM_W'(hist_r[1]) * SUM_W'(W_MID)
              + SUM_W'(hist_r[2]) * SUM_W'(W_OLD);
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign avg  = prod[RECIP_SH +: DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_take) begin
      s3_v_r <= 1'b1;
    end else if (s4_take) begin
      s3_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_med_r <= s2_med_r;
      s3_avg_r <= avg;
    end
  end

  // Stage 4: move drive toward the average by at most the ramp step
  always_comb begin
    if ((s3_avg_r > drive_r) && ((s3_avg_r - drive_r) > ramp_step_r)) begin
      drive_nxt = drive_r + ramp_step_r;
    end else if ((drive_r > s3_avg_r) && ((drive_r - s3_avg_r) > ramp_step_r)) begin
      drive_nxt = drive_r - ramp_step_r;
    end else begin
      drive_nxt = s3_avg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      drive_r     <= '0;
    end else begin
      if (s4_take) begin
        out_valid_r <= 1'b1;
        drive_r     <= drive_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_take) begin
      out_med_r <= s3_med_r;
      out_avg_r <= s3_avg_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_value   = out_med_r;
  assign out_smoothed_value = out_avg_r;
  assign out_drive_value    = drive_r;

endmodule
